// ----- hdl/jhsd_pkg.sv -----
package jhsd_pkg;

  localparam int WIN_BITS = 16;
  localparam int NUM_LEN  = 16;
  localparam int AC_NSYM  = 162;

  localparam logic [7:0] AC_COUNTS [NUM_LEN] = '{
    8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
    8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'd125
  };

  localparam logic [7:0] AC_SYMBOLS [AC_NSYM] = '{
    8'd1,   8'd2,   8'd3,   8'd0,   8'd4,   8'd17,  8'd5,   8'd18,  8'd33,
    8'd49,  8'd65,  8'd6,   8'd19,  8'd81,  8'd97,  8'd7,   8'd34,  8'd113,
    8'd20,  8'd50,  8'd129, 8'd145, 8'd161, 8'd8,   8'd35,  8'd66,  8'd177,
    8'd193, 8'd21,  8'd82,  8'd209, 8'd240, 8'd36,  8'd51,  8'd98,  8'd114,
    8'd130, 8'd9,   8'd10,  8'd22,  8'd23,  8'd24,  8'd25,  8'd26,  8'd37,
    8'd38,  8'd39,  8'd40,  8'd41,  8'd42,  8'd52,  8'd53,  8'd54,  8'd55,
    8'd56,  8'd57,  8'd58,  8'd67,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,
    8'd73,  8'd74,  8'd83,  8'd84,  8'd85,  8'd86,  8'd87,  8'd88,  8'd89,
    8'd90,  8'd99,  8'd100, 8'd101, 8'd102, 8'd103, 8'd104, 8'd105, 8'd106,
    8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd131,
    8'd132, 8'd133, 8'd134, 8'd135, 8'd136, 8'd137, 8'd138, 8'd146, 8'd147,
    8'd148, 8'd149, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd162, 8'd163,
    8'd164, 8'd165, 8'd166, 8'd167, 8'd168, 8'd169, 8'd170, 8'd178, 8'd179,
    8'd180, 8'd181, 8'd182, 8'd183, 8'd184, 8'd185, 8'd186, 8'd194, 8'd195,
    8'd196, 8'd197, 8'd198, 8'd199, 8'd200, 8'd201, 8'd202, 8'd210, 8'd211,
    8'd212, 8'd213, 8'd214, 8'd215, 8'd216, 8'd217, 8'd218, 8'd225, 8'd226,
    8'd227, 8'd228, 8'd229, 8'd230, 8'd231, 8'd232, 8'd233, 8'd234, 8'd241,
    8'd242, 8'd243, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250
  };

  localparam logic OP_AC = 1'b0;
  localparam logic OP_DC = 1'b1;

  typedef logic [WIN_BITS-1:0] win_t;
  typedef logic [WIN_BITS:0]   code_t;

  // first canonical code of length len
  function automatic code_t ac_first(input int len);
    code_t first;
    first = '0;
    for (int l = 1; l < len; l++) begin
      first = code_t'((first + code_t'(AC_COUNTS[l-1])) << 1);
    end
    return first;
  endfunction

  // one past the last code of length len
  function automatic code_t ac_limit(input int len);
    return code_t'(ac_first(len) + code_t'(AC_COUNTS[len-1]));
  endfunction

  // first code of length len minus the number of shorter codes
  function automatic code_t ac_offset(input int len);
    code_t base;
    base = '0;
    for (int l = 1; l < len; l++) begin
      base = code_t'(base + code_t'(AC_COUNTS[l-1]));
    end
    return code_t'(ac_first(len) - base);
  endfunction

  typedef struct packed {
    logic         op;
    win_t         window;
    logic [15:0]  ac_hit;
    logic         dc_hit;
    logic [3:0]   dc_cat;
    logic [4:0]   dc_len;
  } s1_t;

  typedef struct packed {
    logic         match;
    logic         is_ac;
    logic [7:0]   index;
    logic [4:0]   len;
    logic [3:0]   dc_cat;
  } s2_t;

  typedef struct packed {
    logic [4:0]   code_length;
    logic [3:0]   size_category;
    logic [3:0]   run_length;
    logic [7:0]   symbol_index;
    logic         valid_res;
  } res_t;

endpackage

// ----- hdl/jpeg_huffman_symbol_decode.sv -----
// channel  dir  tdata                             tuser
// in_      in   [15:0] window                     [0] operation (0 AC, 1 DC)
// out_     out  [7:0] symbol_index, [11:8] run,   [0] valid_res
//               [15:12] size, [20:16] code_length
//
// Three register stages: length compare and DC match, index, symbol table.
// One item per cycle while out_tready is high; an accepted item passes the
// match, index and lookup registers before out_tvalid rises.
// Synchronous active-low reset clears the stage valid bits only.
// Each stage holds its item while the next is full and stalled, so a
// full pipe of three items waits on out_tready without loss.
module jpeg_huffman_symbol_decode import jhsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] window
  input  logic [0:0]  in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // symbol_index, run_length, size_category, code_length
  output logic [0:0]  out_tuser   // [0] valid_res
);

  logic s1_valid, s2_valid;
  logic s1_ready, s2_ready;
  s1_t  s1_data;
  s2_t  s2_data;
  res_t res;

  jhsd_match u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_op      (in_tuser[0]),
    .in_window  (in_tdata),
    .up_ready   (in_tready),
    .down_ready (s1_ready),
    .valid_r    (s1_valid),
    .data_r     (s1_data)
  );

  jhsd_index u_index (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s1_valid),
    .in_data    (s1_data),
    .up_ready   (s1_ready),
    .down_ready (s2_ready),
    .valid_r    (s2_valid),
    .data_r     (s2_data)
  );

  jhsd_lookup u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s2_valid),
    .in_data    (s2_data),
    .up_ready   (s2_ready),
    .down_ready (out_tready),
    .valid_r    (out_tvalid),
    .data_r     (res)
  );

  assign out_tuser = res.valid_res;
  assign out_tdata = {3'd0, res.code_length, res.size_category, res.run_length,
                      res.symbol_index};

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid && s2_valid && out_tvalid))
    else $error("input stalled with a free stage");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !res.valid_res) |-> (out_tdata == '0))
    else $error("unmatched item carries nonzero fields");

  a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.valid_res) |->
      (res.code_length != 5'd0 && res.code_length <= 5'd16))
    else $error("matched item with bad code length");

  a_dc_len: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && s2_data.match && !s2_data.is_ac) |->
      (s2_data.len >= 5'd2 && s2_data.len <= 5'd9 && s2_data.dc_cat <= 4'd11))
    else $error("DC code length or category out of range");

  a_ac_index: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && s2_data.match && s2_data.is_ac) |-> (s2_data.index < 8'(AC_NSYM)))
    else $error("AC index past symbol table");

endmodule

// ----- hdl/jhsd_match.sv -----
module jhsd_match import jhsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  input  win_t in_window,
  output logic up_ready,
  input  logic down_ready,
  output logic valid_r,
  output s1_t  data_r
);

  logic adv;
  s1_t  data_nxt;

  assign adv      = down_ready || !valid_r;
  assign up_ready = adv;

  always_comb begin
    code_t prefix;
    data_nxt        = '0;
    data_nxt.op     = in_op;
    data_nxt.window = in_window;
    for (int l = 1; l <= NUM_LEN; l++) begin
      prefix = code_t'(in_window >> (WIN_BITS - l));
      data_nxt.ac_hit[l-1] = prefix < ac_limit(l);
    end
    data_nxt.dc_hit = 1'b1;
    case (in_window[15:7]) inside
      9'b00???????: begin data_nxt.dc_cat = 4'd0;  data_nxt.dc_len = 5'd2; end
      9'b010??????: begin data_nxt.dc_cat = 4'd1;  data_nxt.dc_len = 5'd3; end
      9'b011??????: begin data_nxt.dc_cat = 4'd2;  data_nxt.dc_len = 5'd3; end
      9'b100??????: begin data_nxt.dc_cat = 4'd3;  data_nxt.dc_len = 5'd3; end
      9'b101??????: begin data_nxt.dc_cat = 4'd4;  data_nxt.dc_len = 5'd3; end
      9'b110??????: begin data_nxt.dc_cat = 4'd5;  data_nxt.dc_len = 5'd3; end
      9'b1110?????: begin data_nxt.dc_cat = 4'd6;  data_nxt.dc_len = 5'd4; end
      9'b11110????: begin data_nxt.dc_cat = 4'd7;  data_nxt.dc_len = 5'd5; end
      9'b111110???: begin data_nxt.dc_cat = 4'd8;  data_nxt.dc_len = 5'd6; end
      9'b1111110??: begin data_nxt.dc_cat = 4'd9;  data_nxt.dc_len = 5'd7; end
      9'b11111110?: begin data_nxt.dc_cat = 4'd10; data_nxt.dc_len = 5'd8; end
      9'b111111110: begin data_nxt.dc_cat = 4'd11; data_nxt.dc_len = 5'd9; end
      default: begin
        data_nxt.dc_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- hdl/jhsd_index.sv -----
module jhsd_index import jhsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  s1_t  in_data,
  output logic up_ready,
  input  logic down_ready,
  output logic valid_r,
  output s2_t  data_r
);

  logic adv;
  s2_t  data_nxt;

  assign adv      = down_ready || !valid_r;
  assign up_ready = adv;

  always_comb begin
    code_t prefix;
    prefix          = '0;
    data_nxt        = '0;
    data_nxt.is_ac  = (in_data.op == OP_AC);
    data_nxt.dc_cat = in_data.dc_cat;
    if (in_data.op == OP_AC) begin
      // shortest length wins
      for (int l = NUM_LEN; l >= 1; l--) begin
        if (in_data.ac_hit[l-1]) begin
          prefix         = code_t'(in_data.window >> (WIN_BITS - l));
          data_nxt.match = 1'b1;
          data_nxt.len   = 5'(l);
          data_nxt.index = 8'(prefix - ac_offset(l));
        end
      end
    end else begin
      data_nxt.match = in_data.dc_hit;
      data_nxt.len   = in_data.dc_len;
      data_nxt.index = {4'd0, in_data.dc_cat};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- hdl/jhsd_lookup.sv -----
module jhsd_lookup import jhsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  s2_t  in_data,
  output logic up_ready,
  input  logic down_ready,
  output logic valid_r,
  output res_t data_r
);

  logic adv;
  res_t data_nxt;

  assign adv      = down_ready || !valid_r;
  assign up_ready = adv;

  always_comb begin
    logic [7:0] sym;
    sym = '0;
    if (in_data.index < 8'(AC_NSYM)) begin
      sym = AC_SYMBOLS[in_data.index];
    end
    data_nxt = '0;
    if (in_data.match) begin
      data_nxt.valid_res    = 1'b1;
      data_nxt.symbol_index = in_data.index;
      data_nxt.code_length  = in_data.len;
      if (in_data.is_ac) begin
        data_nxt.run_length    = sym[7:4];
        data_nxt.size_category = sym[3:0];
      end else begin
        data_nxt.size_category = in_data.dc_cat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
